// File: rtl/core/tone_queue_player_defines.svh
// ----------------------------------------------------------------------------
// tone_queue_player_defines
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef TONE_QUEUE_PLAYER_DEFINES_SVH
`define TONE_QUEUE_PLAYER_DEFINES_SVH

// same-cycle implication, disabled while reset is high
`define TQP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tone_queue_player check failed");

// next-cycle implication, disabled while reset is high
`define TQP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tone_queue_player check failed");

`endif

// File: rtl/core/tqp_pkg.sv
// ----------------------------------------------------------------------------
// tqp_pkg
// codes and fixed widths of the tone queue player
// ----------------------------------------------------------------------------
package tqp_pkg;

  localparam int CLK_W  = 22;
  localparam int FREQ_W = 16;
  localparam int DUR_W  = 16;
  localparam int CNT5_W = 5;

  localparam logic [CLK_W-1:0] BASE_CLOCK_RESET = 22'd1600000;

  // one quotient bit per divider step
  localparam int DIV_STEPS = CLK_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  typedef logic [1:0] func_t;
  typedef logic [1:0] status_t;

  localparam func_t FUNC_TICK    = 2'd0;
  localparam func_t FUNC_PUSH    = 2'd1;
  localparam func_t FUNC_RESERVE = 2'd2;

  localparam status_t STATUS_OK      = 2'd0;
  localparam status_t STATUS_FULL    = 2'd1;
  localparam status_t STATUS_REFUSED = 2'd2;
  localparam status_t STATUS_DROPPED = 2'd3;

endpackage

// File: rtl/core/tone_queue_player.sv
// ----------------------------------------------------------------------------
// tone_queue_player: note fifo driving a pwm tone, with a serial period divider
// result via S_DONE after a transfer; a popped rest passes S_RDMEM and S_LOAD first,
// a popped tone also S_DIV; not ready until S_DONE registers the result: one item at a time
// sync reset empties the queue and stops playback
// ----------------------------------------------------------------------------
module tone_queue_player #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [tqp_pkg::CLK_W-1:0]   cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  func,
  input  logic [tqp_pkg::FREQ_W-1:0]  frequency,
  input  logic [tqp_pkg::DUR_W-1:0]   duration_ms,
  input  logic [tqp_pkg::CNT5_W-1:0]  batch_count,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  status,
  output logic                        playing,
  output logic [tqp_pkg::CLK_W-1:0]   reload_value,
  output logic [tqp_pkg::CLK_W-2:0]   compare_value,
  output logic [tqp_pkg::DUR_W-1:0]   remaining_ms,
  output logic [3:0]                  queued_notes
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = (PTR_W > 4) ? PTR_W : 4;
  localparam int CMP_W = (CNT_W > tqp_pkg::CNT5_W) ? CNT_W : tqp_pkg::CNT5_W;
  localparam int NOTE_W = tqp_pkg::FREQ_W + tqp_pkg::DUR_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RDMEM = 3'd1;
  localparam logic [2:0] S_LOAD  = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]                   state;
  logic [PTR_W-1:0]             rd_ptr;
  logic [PTR_W-1:0]             wr_ptr;
  logic [tqp_pkg::DUR_W-1:0]    countdown;
  logic                         tone_on;
  logic [tqp_pkg::CLK_W-1:0]    period;
  logic [tqp_pkg::CLK_W-2:0]    duty;
  logic [tqp_pkg::CNT5_W-1:0]   drop_pending;
  logic [tqp_pkg::CLK_W-1:0]    base_clock;
  tqp_pkg::status_t             status_hold;

  logic [NOTE_W-1:0]            note_mem [QUEUE_DEPTH];
  logic [NOTE_W-1:0]            rd_data;

  logic [tqp_pkg::FREQ_W-1:0]   div_den;
  logic [tqp_pkg::FREQ_W-1:0]   div_rem;
  logic [tqp_pkg::CLK_W-1:0]    div_quo;
  logic [tqp_pkg::DIV_CNT_W-1:0] div_cnt;

  logic                         accept;
  logic                         mem_we;
  logic [CNT_W-1:0]             used_slots;
  logic [CNT_W-1:0]             free_slots;
  logic                         batch_too_big;
  logic [tqp_pkg::DUR_W-1:0]    countdown_dec;
  logic [tqp_pkg::FREQ_W:0]     div_shift;
  logic [tqp_pkg::FREQ_W+1:0]   div_diff;
  logic                         div_borrow;
  logic [PTR_W-1:0]             rd_ptr_inc;
  logic [PTR_W-1:0]             wr_ptr_inc;

  assign cfg_ready = !rst;
  assign in_ready  = (state == S_IDLE) && !rst;
  assign accept    = in_valid && in_ready;

  always_comb begin
    if (wr_ptr >= rd_ptr) begin
      used_slots = CNT_W'(wr_ptr) - CNT_W'(rd_ptr);
    end else begin
      used_slots = CNT_W'(QUEUE_DEPTH) + CNT_W'(wr_ptr) - CNT_W'(rd_ptr);
    end
    free_slots    = CNT_W'(QUEUE_DEPTH - 1) - used_slots;
    batch_too_big = CMP_W'(batch_count) > CMP_W'(free_slots);
    countdown_dec = (countdown != '0) ? countdown - 1'b1 : countdown;
    rd_ptr_inc    = (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
    wr_ptr_inc    = (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
  end

  assign mem_we = accept && (func == tqp_pkg::FUNC_PUSH) && (drop_pending == '0) &&
                  (free_slots != '0);

  // restoring divide step: shift in the next dividend bit, try the subtract
  assign div_shift  = {div_rem, div_quo[tqp_pkg::CLK_W-1]};
  assign div_diff   = {1'b0, div_shift} - {2'b00, div_den};
  assign div_borrow = div_diff[tqp_pkg::FREQ_W+1];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      note_mem[wr_ptr] <= {frequency, duration_ms};
    end
    if (state == S_RDMEM) begin
      rd_data <= note_mem[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_clock <= tqp_pkg::BASE_CLOCK_RESET;
    end else if (cfg_valid && cfg_ready) begin
      base_clock <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      rd_ptr       <= '0;
      wr_ptr       <= '0;
      countdown    <= '0;
      tone_on      <= 1'b0;
      period       <= '0;
      duty         <= '0;
      drop_pending <= '0;
      out_valid    <= 1'b0;
      status_hold  <= tqp_pkg::STATUS_OK;
      div_cnt      <= '0;
    end else begin
      // in S_DONE the output register is refilled instead
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (func)
              tqp_pkg::FUNC_TICK: begin
                countdown   <= countdown_dec;
                status_hold <= tqp_pkg::STATUS_OK;
                if ((countdown_dec == '0) && (rd_ptr != wr_ptr)) begin
                  state <= S_RDMEM;
                end else begin
                  state <= S_DONE;
                end
                if ((countdown_dec == '0) && (rd_ptr == wr_ptr)) begin
                  tone_on <= 1'b0;
                end
              end
              tqp_pkg::FUNC_PUSH: begin
                state <= S_DONE;
                if (drop_pending != '0) begin
                  drop_pending <= drop_pending - 1'b1;
                  status_hold  <= tqp_pkg::STATUS_DROPPED;
                end else if (free_slots == '0) begin
                  status_hold <= tqp_pkg::STATUS_FULL;
                end else begin
                  wr_ptr      <= wr_ptr_inc;
                  status_hold <= tqp_pkg::STATUS_OK;
                end
              end
              tqp_pkg::FUNC_RESERVE: begin
                state <= S_DONE;
                if (batch_too_big) begin
                  drop_pending <= batch_count;
                  status_hold  <= tqp_pkg::STATUS_REFUSED;
                end else begin
                  drop_pending <= '0;
                  status_hold  <= tqp_pkg::STATUS_OK;
                end
              end
              default: begin
                state       <= S_DONE;
                status_hold <= tqp_pkg::STATUS_OK;
              end
            endcase
          end
        end
        S_RDMEM: begin
          state <= S_LOAD;
        end
        S_LOAD: begin
          rd_ptr    <= rd_ptr_inc;
          countdown <= rd_data[tqp_pkg::DUR_W-1:0];
          tone_on   <= 1'b1;
          div_den   <= rd_data[NOTE_W-1:tqp_pkg::DUR_W];
          div_rem   <= '0;
          div_quo   <= base_clock;
          div_cnt   <= tqp_pkg::DIV_CNT_W'(tqp_pkg::DIV_STEPS);
          if (rd_data[NOTE_W-1:tqp_pkg::DUR_W] == '0) begin
            // rest: silent but still counting down
            period <= '0;
            duty   <= '0;
            state  <= S_DONE;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          div_rem <= div_borrow ? div_shift[tqp_pkg::FREQ_W-1:0]
                                : div_diff[tqp_pkg::FREQ_W-1:0];
          div_quo <= {div_quo[tqp_pkg::CLK_W-2:0], !div_borrow};
          div_cnt <= div_cnt - 1'b1;
          if (div_cnt == tqp_pkg::DIV_CNT_W'(1)) begin
            period <= {div_quo[tqp_pkg::CLK_W-2:0], !div_borrow};
            duty   <= div_quo[tqp_pkg::CLK_W-2:0];
            state  <= S_DONE;
          end
        end
        S_DONE: begin
          // output register frees up when the previous result transfers
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && (!out_valid || out_ready)) begin
      status        <= status_hold;
      playing       <= tone_on;
      reload_value  <= period;
      compare_value <= duty;
      remaining_ms  <= countdown;
      queued_notes  <= used_slots[3:0];
    end
  end

endmodule

// File: rtl/core/tqp_checker.sv
// ----------------------------------------------------------------------------
// tqp_checker
// port-level checks of the tone queue player, bound to the top level
// ----------------------------------------------------------------------------
`include "tone_queue_player_defines.svh"

module tqp_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [tqp_pkg::CLK_W-1:0] reload_value,
  input logic [tqp_pkg::CLK_W-2:0] compare_value
);

  // one item in flight: no new transfer right after one is taken
  `TQP_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready)

  // a shown result is not withdrawn before it transfers
  `TQP_ASSERT_NEXT(a_out_holds, out_valid && !out_ready, out_valid)

  // compare is always half the period
  `TQP_ASSERT_IMP(a_half_duty, out_valid,
                  compare_value == reload_value[tqp_pkg::CLK_W-1:1])

endmodule

bind tone_queue_player tqp_checker u_tqp_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .reload_value  (reload_value),
  .compare_value (compare_value)
);
